>>> hw/rtl/schm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schm_pkg: shared types and constants for the spin chain row engine
// item structs, controller/datapath command and status, register codes
// ----------------------------------------------------------------------------
package schm_pkg;

    // fixed field widths
    localparam int IDX_W      = 10;
    localparam int AMP_W      = 16;
    localparam int CPL_W      = 16;
    localparam int ACC_W      = 48;
    localparam int MODEL_W    = 2;
    localparam int SITES_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // internal arithmetic widths
    localparam int BOND_W = 6;   // signed bond sum over the chain's bonds
    localparam int WT_W   = 24;  // signed weight applied to one amplitude
    localparam int PROD_W = 40;  // weight times amplitude

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_J   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_JZ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_GAMMA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SITES    = 3'd4;

    // model codes
    localparam logic [MODEL_W-1:0] MODEL_ISING = 2'd0;
    localparam logic [MODEL_W-1:0] MODEL_XXZ   = 2'd1;

    // item commands
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // register reset values
    localparam logic [MODEL_W-1:0]      MODEL_RESET = MODEL_ISING;
    localparam logic signed [CPL_W-1:0] CPL_RESET   = 16'sd4096;
    localparam logic [SITES_W-1:0]      SITES_RESET = 4'd10;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         state_index;
        logic signed [AMP_W-1:0]  amp_re;
        logic signed [AMP_W-1:0]  amp_im;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [ACC_W-1:0]  out_re;
        logic signed [ACC_W-1:0]  out_im;
    } result_t;

    typedef struct packed {
        logic load;   // take a new item
        logic write;  // item is an amplitude write
        logic flip;   // read one flipped neighbor
        logic own;    // read the own amplitude
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_flip;
        logic no_flips;
    } dp_status_t;

endpackage

>>> hw/rtl/spin_chain_hamiltonian_matvec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spin_chain_hamiltonian_matvec: one row of H times psi for an open spin chain
// amplitude store with write items and row compute items, ising or xxz
// ----------------------------------------------------------------------------
// usage
// - an item is taken at a rising edge with start high and busy low; request
//   carries the command, the basis index and, for writes, the amplitude
// - every item gives one result on result, valid for the single cycle in
//   which done is high; there is no backpressure, the receiver must take it
// - a write lands in the store at the accepting edge; its result (index,
//   zero sums) follows in the next cycle and a new item can be taken at the
//   end of that cycle, so writes run at one per cycle
// - a compute reads one neighbor amplitude per cycle from the single read
//   port of the store: n neighbors for ising, n-1 pairs for xxz/heisenberg,
//   then the own amplitude, then the multiply and accumulate states
// - a compute steps through L flip states, L = n for ising and n-1
//   otherwise (zero with no sites), then own, mul, acc and done; the next
//   item is taken in the done cycle
// - config writes (cfg_write, cfg_addr, cfg_data) take effect at the edge
//   and are allowed only while the block is idle
// - reset clears the sequencer and loads the register defaults; the store
//   is not cleared, reading an entry never written gives undefined sums
// ----------------------------------------------------------------------------
module spin_chain_hamiltonian_matvec #(
    parameter int MAX_SITES = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  schm_pkg::request_t               request,
    output logic                             done,
    output schm_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [schm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [schm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import schm_pkg::*;

    localparam int CNT_W = $clog2(MAX_SITES + 1);

    // command and status between sequencer and datapath
    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [CNT_W-1:0] site_cnt;

    schm_ctrl #(
        .MAX_SITES (MAX_SITES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (request.command),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd),
        .status   (status),
        .site_cnt (site_cnt)
    );

    schm_dp #(
        .MAX_SITES (MAX_SITES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .site_cnt  (site_cnt),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result)
    );

    // a result cycle always leaves the block free for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("done raised while busy");

    // a write item reports in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command == CMD_WRITE) |=> done)
    else $error("write item result missing");

    // a compute item needs the store pipeline, no result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command == CMD_COMPUTE) |=> (!done && busy))
    else $error("compute item finished too early");

    // no item is taken between an accepted compute and its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy) && !done) |-> ##1 (busy || done))
    else $error("busy dropped without a result");

endmodule

>>> hw/rtl/schm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schm_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module schm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

>>> hw/rtl/schm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schm_ctrl: sequencer for the row engine
// steps through neighbor reads, the own read and the pipeline drain
// ----------------------------------------------------------------------------
module schm_ctrl #(
    parameter int MAX_SITES = 10,
    localparam int CNT_W = $clog2(MAX_SITES + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   command,
    output logic                   busy,
    output logic                   done,
    output schm_pkg::ctrl_cmd_t    cmd,
    input  schm_pkg::dp_status_t   status,
    output logic [CNT_W-1:0]       site_cnt
);

    import schm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FLIP = 6'b000010,
        ST_OWN  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             free;

    assign free = (state_reg == ST_IDLE) || (state_reg == ST_DONE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg) inside
            ST_IDLE, ST_DONE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    cmd.write = (command == CMD_WRITE);
                    cnt_next  = '0;
                    if (command == CMD_WRITE)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (status.no_flips)
                    begin
                        state_next = ST_OWN;
                    end
                    else
                    begin
                        state_next = ST_FLIP;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLIP:
            begin
                cmd.flip = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (status.last_flip)
                begin
                    state_next = ST_OWN;
                end
            end
            ST_OWN:
            begin
                cmd.own    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy     = !free;
    assign done     = (state_reg == ST_DONE);
    assign site_cnt = cnt_reg;

endmodule

>>> hw/rtl/schm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schm_dp: datapath of the row engine
// config registers, amplitude store, weight multiply and accumulate
// ----------------------------------------------------------------------------
module schm_dp #(
    parameter int MAX_SITES = 10,
    localparam int ADDR_W = MAX_SITES,
    localparam int CNT_W  = $clog2(MAX_SITES + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  schm_pkg::request_t                 request,
    input  schm_pkg::ctrl_cmd_t                cmd,
    input  logic [CNT_W-1:0]                   site_cnt,
    input  logic                               cfg_write,
    input  logic [schm_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [schm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output schm_pkg::dp_status_t               status,
    output schm_pkg::result_t                  result
);

    import schm_pkg::*;

    // configuration
    logic [MODEL_W-1:0]      model_reg;
    logic signed [CPL_W-1:0] j_reg;
    logic signed [CPL_W-1:0] jz_reg;
    logic signed [CPL_W-1:0] gamma_reg;
    logic [SITES_W-1:0]      sites_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= MODEL_RESET;
            j_reg     <= CPL_RESET;
            jz_reg    <= CPL_RESET;
            gamma_reg <= CPL_RESET;
            sites_reg <= SITES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                CFG_MODEL_SELECT: model_reg <= cfg_data[MODEL_W-1:0];
                CFG_COUPLING_J:   j_reg     <= cfg_data;
                CFG_COUPLING_JZ:  jz_reg    <= cfg_data;
                CFG_FIELD_GAMMA:  gamma_reg <= cfg_data;
                CFG_NUM_SITES:    sites_reg <= cfg_data[SITES_W-1:0];
                default:          ;
            endcase
        end
    end

    // sites in use, index mask, loop length
    logic [CNT_W-1:0]        n_use;
    logic [CNT_W-1:0]        loop_len;
    logic [CNT_W-1:0]        cnt_p1;
    logic [ADDR_W-1:0]       mask;
    logic [ADDR_W+IDX_W-1:0] s_wide;
    logic [ADDR_W-1:0]       s_in;
    logic                    ising;

    always_comb
    begin
        if (int'(sites_reg) > MAX_SITES)
        begin
            n_use = CNT_W'(MAX_SITES);
        end
        else
        begin
            n_use = CNT_W'(sites_reg);
        end
        for (int k = 0; k < ADDR_W; k++)
        begin
            mask[k] = (k < int'(n_use));
        end
    end

    assign ising    = (model_reg == MODEL_ISING);
    assign loop_len = ising ? n_use : ((n_use == '0) ? '0 : n_use - CNT_W'(1));
    assign cnt_p1   = site_cnt + CNT_W'(1);
    assign s_wide   = {{ADDR_W{1'b0}}, request.state_index};
    assign s_in     = s_wide[ADDR_W-1:0] & mask;

    assign status.last_flip = (cnt_p1 == loop_len);
    assign status.no_flips  = (loop_len == '0);

    // weights
    logic signed [WT_W-1:0] j_w, jz_w, gamma_w, coef, flip_w, wsel;

    assign j_w     = WT_W'(j_reg);
    assign jz_w    = WT_W'(jz_reg);
    assign gamma_w = WT_W'(gamma_reg);
    // diagonal per bond: -4J for ising, jz otherwise (jz is j outside xxz)
    assign coef    = ising ? -(j_w <<< 2) : ((model_reg == MODEL_XXZ) ? jz_w : j_w);
    // neighbor weight: -4 gamma for ising, 2J for a flipped pair
    assign flip_w  = ising ? -(gamma_w <<< 2) : (j_w <<< 1);

    // read address and bond bookkeeping
    logic [ADDR_W-1:0]       s_reg;
    logic [ADDR_W-1:0]       s_shift;
    logic [ADDR_W-1:0]       flip_mask;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    anti;
    logic                    bond_ok;
    logic                    take0;
    logic signed [BOND_W-1:0] bond_reg, bond_next;

    assign s_shift   = s_reg >> site_cnt;
    assign anti      = s_shift[0] ^ s_shift[1];
    assign bond_ok   = (cnt_p1 < n_use);
    assign flip_mask = ising ? (ADDR_W'(1) << site_cnt) : (ADDR_W'(3) << site_cnt);
    assign rd_addr   = cmd.own ? s_reg : (s_reg ^ flip_mask);
    // parallel pairs in xxz contribute nothing and their entry is not read
    assign take0     = cmd.own | (cmd.flip & (ising | anti));

    always_comb
    begin
        bond_next = bond_reg;
        if (cmd.load)
        begin
            bond_next = '0;
        end
        else if (cmd.flip && bond_ok)
        begin
            bond_next = anti ? bond_reg - BOND_W'(1) : bond_reg + BOND_W'(1);
        end
    end

    // amplitude store
    logic [2*AMP_W-1:0]      rd_data;
    logic signed [AMP_W-1:0] rd_re, rd_im;

    schm_ram #(
        .WIDTH (2 * AMP_W),
        .DEPTH (1 << MAX_SITES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load & cmd.write),
        .waddr (s_in),
        .wdata ({request.amp_im, request.amp_re}),
        .re    (take0),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_re = rd_data[AMP_W-1:0];
    assign rd_im = rd_data[2*AMP_W-1:AMP_W];

    // multiply and accumulate pipeline
    logic signed [WT_W-1:0]   diag_reg, w1_reg;
    logic                     own1_reg, take1_reg, take2_reg;
    logic signed [PROD_W-1:0] prod_re, prod_im;
    logic signed [PROD_W-1:0] p_re_reg, p_im_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;

    assign wsel    = own1_reg ? diag_reg : w1_reg;
    assign prod_re = wsel * rd_re;
    assign prod_im = wsel * rd_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own1_reg  <= 1'b0;
            take1_reg <= 1'b0;
            take2_reg <= 1'b0;
        end
        else
        begin
            own1_reg  <= cmd.own;
            take1_reg <= take0;
            take2_reg <= take1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg <= s_in;
        end
        bond_reg <= bond_next;
        diag_reg <= coef * WT_W'(bond_reg);
        w1_reg   <= flip_w;
        p_re_reg <= prod_re;
        p_im_reg <= prod_im;
        if (cmd.load)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (take2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(p_re_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(p_im_reg);
        end
    end

    logic [IDX_W+ADDR_W-1:0] idx_wide;

    assign idx_wide         = {{IDX_W{1'b0}}, s_reg};
    assign result.out_index = idx_wide[IDX_W-1:0];
    assign result.out_re    = acc_re_reg;
    assign result.out_im    = acc_im_reg;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the spin chain row engine
// a short table of hand-made items walks the corner cases (extreme indexes
// and amplitudes, every model, zero, one and saturated site counts, ignored
// register writes), then phases of random register settings each run a mix
// of amplitude writes and row computes; every result is checked field by
// field against a local model of the row sum
// ----------------------------------------------------------------------------
module tb_top;

    import schm_pkg::*;

    // model codes without a name in the package
    localparam logic [MODEL_W-1:0] MODEL_HEISENBERG = 2'd2;
    localparam logic [MODEL_W-1:0] MODEL_SPARE      = 2'd3;  // acts as heisenberg

    localparam int ITEM_TARGET  = 1650;  // stop issuing items past this count
    localparam int QUIET_AFTER  = 1450;  // no sender gaps after this count
    localparam int REPORT_LIMIT = 10;    // mismatches printed in full

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    request_t              request   = '0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    result_t               result;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spin_chain_hamiltonian_matvec #(
        .MAX_SITES(10)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // local copy of the block state: registers and amplitude store
    // ------------------------------------------------------------------
    logic [MODEL_W-1:0] cfg_model = MODEL_RESET;
    longint             cpl_j     = longint'(CPL_RESET);
    longint             cpl_jz    = longint'(CPL_RESET);
    longint             cpl_gamma = longint'(CPL_RESET);
    logic [SITES_W-1:0] sites_reg = SITES_RESET;

    logic [31:0] psi_copy  [1024];  // im in the upper half, re in the lower
    bit          psi_valid [1024];  // entry has been written at least once

    result_t hpsi_due [$];          // expected rows, oldest first
    result_t hpsi_head;
    int      flaws       = 0;
    int      items_taken = 0;
    bit      burst_ok    = 1'b1;    // sender may insert gaps in this phase

    // directed table
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  addr;
        logic [CFG_DATA_W-1:0] data;
        request_t              req;
        bit                    typed;  // expected row typed in below
        result_t               want;
    } plan_row_t;

    plan_row_t plan [$];

    // ------------------------------------------------------------------
    // row model
    // ------------------------------------------------------------------
    // site count saturates at the store size
    function automatic int sites_used();
        return (sites_reg > 4'd10) ? 10 : int'(sites_reg);
    endfunction

    function automatic logic [IDX_W-1:0] row_mask();
        return IDX_W'((1 << sites_used()) - 1);
    endfunction

    function automatic longint amp_part(logic [IDX_W-1:0] idx, bit im);
        logic [31:0] w;
        w = psi_copy[idx];
        return im ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
    endfunction

    // applies one item to the local state and returns its row, all sums
    // at scale 2^-29 so that -J, Jz/4 and J/2 become whole multiples
    function automatic result_t hpsi_row(request_t r);
        result_t          y;
        int               n;
        logic [IDX_W-1:0] s;
        logic [IDX_W-1:0] nb;
        longint           bonds;
        longint           diag;
        longint           wt;
        longint           jz;
        longint           yre;
        longint           yim;
        bit               ising;
        n   = sites_used();
        s   = r.state_index & row_mask();
        yre = 0;
        yim = 0;
        if (r.command == CMD_WRITE)
        begin
            psi_copy[s] = {r.amp_im, r.amp_re};
        end
        else
        begin
            // spin product per bond is +1 when the two bits agree
            bonds = 0;
            for (int i = 0; i + 1 < n; i++)
                bonds += (s[i] == s[i+1]) ? 1 : -1;
            ising = (cfg_model == MODEL_ISING);
            jz    = (cfg_model == MODEL_XXZ) ? cpl_jz : cpl_j;
            diag  = ising ? -4 * cpl_j * bonds : jz * bonds;
            yre   = diag * amp_part(s, 1'b0);
            yim   = diag * amp_part(s, 1'b1);
            if (ising)
            begin
                // one transverse flip per site
                wt = -4 * cpl_gamma;
                for (int i = 0; i < n; i++)
                begin
                    nb   = s ^ (IDX_W'(1) << i);
                    yre += wt * amp_part(nb, 1'b0);
                    yim += wt * amp_part(nb, 1'b1);
                end
            end
            else
            begin
                // exchange only swaps antiparallel neighbors
                wt = 2 * cpl_j;
                for (int i = 0; i + 1 < n; i++)
                begin
                    if (s[i] != s[i+1])
                    begin
                        nb   = s ^ (IDX_W'(3) << i);
                        yre += wt * amp_part(nb, 1'b0);
                        yim += wt * amp_part(nb, 1'b1);
                    end
                end
            end
        end
        y.out_index = s;
        y.out_re    = yre[ACC_W-1:0];
        y.out_im    = yim[ACC_W-1:0];
        return y;
    endfunction

    // ------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_amp();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_coupling();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short chains, some empty, a few long ones from nine sites up to past the store size
    function automatic logic [15:0] pick_sites();
        int         roll;
        logic [3:0] n;
        roll = $urandom_range(0, 19);
        if (roll < 13)
            n = 4'($urandom_range(1, 5));
        else if (roll < 16)
            n = 4'($urandom_range(6, 8));
        else if (roll < 18)
            n = 4'd0;
        else
            n = 4'($urandom_range(9, 15));
        return {12'($urandom), n};
    endfunction

    // ------------------------------------------------------------------
    // table rows
    // ------------------------------------------------------------------
    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] a, logic [15:0] d);
        plan_row_t p;
        p        = '{default: '0};
        p.is_cfg = 1'b1;
        p.addr   = a;
        p.data   = d;
        return p;
    endfunction

    function automatic plan_row_t item_row(logic cmd, logic [IDX_W-1:0] idx,
                                           logic [15:0] re, logic [15:0] im,
                                           bit typed, logic [IDX_W-1:0] want_idx);
        plan_row_t p;
        p                     = '{default: '0};
        p.req.command         = cmd;
        p.req.state_index     = idx;
        p.req.amp_re          = re;
        p.req.amp_im          = im;
        p.typed               = typed;
        p.want.out_index      = want_idx;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    // presents one item from a falling edge and holds it until taken
    task automatic send_item(input request_t r, input bit typed, input result_t want);
        result_t row;
        if (burst_ok && items_taken < QUIET_AFTER && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // taken at this edge, config cannot change under it
        row = hpsi_row(r);
        hpsi_due.push_back(typed ? want : row);
        if (r.command == CMD_WRITE)
            psi_valid[r.state_index & row_mask()] = 1'b1;
        items_taken++;
    endtask

    // writes any amplitude a compute at s could touch, so that no entry is
    // read before it was written; covers both flip patterns whatever the model
    task automatic cover_neighbors(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] spots [$];
        logic [IDX_W-1:0] m;
        request_t         w;
        int               n;
        n = sites_used();
        m = row_mask();
        spots.push_back(s);
        for (int i = 0; i < n; i++)
            spots.push_back(s ^ (IDX_W'(1) << i));
        for (int i = 0; i + 1 < n; i++)
            spots.push_back(s ^ (IDX_W'(3) << i));
        foreach (spots[k])
        begin
            if (!psi_valid[spots[k]])
            begin
                w.command     = CMD_WRITE;
                w.state_index = spots[k] | (IDX_W'($urandom) & ~m);  // upper bits ignored
                w.amp_re      = rand_amp();
                w.amp_im      = rand_amp();
                send_item(w, 1'b0, '0);
            end
        end
    endtask

    // stop issuing and wait for every outstanding row
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (hpsi_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_poke(input logic [CFG_IDX_W-1:0] a, input logic [15:0] d);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= d;
        @(posedge clk);
        case (a)
            CFG_MODEL_SELECT: cfg_model = d[MODEL_W-1:0];
            CFG_COUPLING_J:   cpl_j     = longint'($signed(d));
            CFG_COUPLING_JZ:  cpl_jz    = longint'($signed(d));
            CFG_FIELD_GAMMA:  cpl_gamma = longint'($signed(d));
            CFG_NUM_SITES:    sites_reg = d[SITES_W-1:0];
            default: ;  // unused indexes change nothing
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result check: one row per done cycle, against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (hpsi_due.size() == 0)
            begin
                flaws++;
                if (flaws <= REPORT_LIMIT)
                    $display("tb_top: row with nothing pending: index %0d re %0d im %0d",
                             result.out_index, result.out_re, result.out_im);
            end
            else
            begin
                hpsi_head = hpsi_due.pop_front();
                if (result.out_index !== hpsi_head.out_index ||
                    result.out_re !== hpsi_head.out_re ||
                    result.out_im !== hpsi_head.out_im)
                begin
                    flaws++;
                    if (flaws <= REPORT_LIMIT)
                        $display("tb_top: row mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 hpsi_head.out_index, hpsi_head.out_re, hpsi_head.out_im,
                                 result.out_index, result.out_re, result.out_im);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        request_t         r;
        logic [IDX_W-1:0] m;
        int               phase;
        int               span;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: ising, ten sites; writes give their index and zero sums
        plan.push_back(item_row(CMD_WRITE, 10'h3ff, 16'h7fff, 16'h8000, 1'b1, 10'h3ff));
        plan.push_back(item_row(CMD_WRITE, 10'h000, 16'h8000, 16'h7fff, 1'b1, 10'h000));
        // two sites, upper index bits dropped on writes
        plan.push_back(cfg_row(CFG_NUM_SITES, 16'd2));
        plan.push_back(item_row(CMD_WRITE, 10'h3fd, 16'h7fff, 16'h7fff, 1'b1, 10'h001));
        plan.push_back(item_row(CMD_WRITE, 10'h002, 16'h8000, 16'h8000, 1'b1, 10'h002));
        plan.push_back(item_row(CMD_WRITE, 10'h3ff, 16'h1234, 16'hedcb, 1'b1, 10'h003));
        plan.push_back(item_row(CMD_COMPUTE, 10'h000, 16'h0, 16'h0, 1'b0, 10'h0));
        plan.push_back(item_row(CMD_COMPUTE, 10'h3fe, 16'h0, 16'h0, 1'b0, 10'h0));
        // extreme couplings in ising
        plan.push_back(cfg_row(CFG_COUPLING_J, 16'h8000));
        plan.push_back(cfg_row(CFG_FIELD_GAMMA, 16'h7fff));
        plan.push_back(item_row(CMD_COMPUTE, 10'h001, 16'h0, 16'h0, 1'b0, 10'h0));
        plan.push_back(item_row(CMD_COMPUTE, 10'h003, 16'h0, 16'h0, 1'b0, 10'h0));
        // xxz with its own jz
        plan.push_back(cfg_row(CFG_MODEL_SELECT, 16'(MODEL_XXZ)));
        plan.push_back(cfg_row(CFG_COUPLING_JZ, 16'h8000));
        plan.push_back(cfg_row(CFG_COUPLING_J, 16'h7fff));
        plan.push_back(item_row(CMD_COMPUTE, 10'h001, 16'h0, 16'h0, 1'b0, 10'h0));
        plan.push_back(item_row(CMD_COMPUTE, 10'h002, 16'h0, 16'h0, 1'b0, 10'h0));
        plan.push_back(item_row(CMD_COMPUTE, 10'h000, 16'h0, 16'h0, 1'b0, 10'h0));
        // spare model code behaves as heisenberg, then heisenberg itself
        plan.push_back(cfg_row(CFG_MODEL_SELECT, 16'(MODEL_SPARE)));
        plan.push_back(item_row(CMD_COMPUTE, 10'h002, 16'h0, 16'h0, 1'b0, 10'h0));
        plan.push_back(cfg_row(CFG_MODEL_SELECT, 16'(MODEL_HEISENBERG)));
        plan.push_back(item_row(CMD_COMPUTE, 10'h001, 16'h0, 16'h0, 1'b0, 10'h0));
        // no sites: every index folds to zero and a row sums to nothing
        plan.push_back(cfg_row(CFG_NUM_SITES, 16'd0));
        plan.push_back(item_row(CMD_COMPUTE, 10'h3ff, 16'h0, 16'h0, 1'b1, 10'h000));
        plan.push_back(item_row(CMD_WRITE, 10'h155, 16'h4000, 16'hc000, 1'b1, 10'h000));
        // one site: no bonds, ising keeps its single flip
        plan.push_back(cfg_row(CFG_NUM_SITES, 16'd1));
        plan.push_back(cfg_row(CFG_MODEL_SELECT, 16'(MODEL_ISING)));
        plan.push_back(item_row(CMD_COMPUTE, 10'h3fe, 16'h0, 16'h0, 1'b0, 10'h0));
        plan.push_back(item_row(CMD_COMPUTE, 10'h001, 16'h0, 16'h0, 1'b0, 10'h0));
        // writes past the register list must leave everything alone
        plan.push_back(cfg_row(3'd5, 16'hffff));
        plan.push_back(cfg_row(3'd7, 16'h0000));
        plan.push_back(item_row(CMD_COMPUTE, 10'h001, 16'h0, 16'h0, 1'b0, 10'h0));
        // site count past the store size saturates to the full index
        plan.push_back(cfg_row(CFG_NUM_SITES, 16'd15));
        plan.push_back(item_row(CMD_WRITE, 10'h3ff, 16'h0000, 16'h0000, 1'b1, 10'h3ff));
        plan.push_back(item_row(CMD_WRITE, 10'h200, 16'hffff, 16'h0001, 1'b1, 10'h200));

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
            begin
                settle();
                cfg_poke(plan[k].addr, plan[k].data);
            end
            else
            begin
                send_item(plan[k].req, plan[k].typed, plan[k].want);
            end
        end

        // random phases, each under fresh settings
        phase = 0;
        while (items_taken < ITEM_TARGET)
        begin
            settle();
            if (phase == 0)
            begin
                // full chain, ising at opposite coupling extremes
                cfg_poke(CFG_MODEL_SELECT, 16'(MODEL_ISING));
                cfg_poke(CFG_COUPLING_J, 16'h7fff);
                cfg_poke(CFG_COUPLING_JZ, 16'h0001);
                cfg_poke(CFG_FIELD_GAMMA, 16'h8000);
                cfg_poke(CFG_NUM_SITES, 16'd10);
            end
            else if (phase == 1)
            begin
                // full chain, xxz with jz and j at opposite extremes
                cfg_poke(CFG_MODEL_SELECT, 16'(MODEL_XXZ));
                cfg_poke(CFG_COUPLING_J, 16'h8000);
                cfg_poke(CFG_COUPLING_JZ, 16'h7fff);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    cfg_poke(CFG_MODEL_SELECT, {14'($urandom), 2'($urandom_range(0, 3))});
                if ($urandom_range(0, 1) == 0)
                    cfg_poke(CFG_COUPLING_J, rand_coupling());
                if ($urandom_range(0, 1) == 0)
                    cfg_poke(CFG_COUPLING_JZ, rand_coupling());
                if ($urandom_range(0, 1) == 0)
                    cfg_poke(CFG_FIELD_GAMMA, rand_coupling());
                cfg_poke(CFG_NUM_SITES, pick_sites());
                if ($urandom_range(0, 7) == 0)
                    cfg_poke(3'($urandom_range(5, 7)), 16'($urandom));
            end
            phase++;

            // some phases run back to back with no sender gaps
            burst_ok = ($urandom_range(0, 3) != 0);
            // long chains need many fill writes, keep their phases short
            span = (sites_used() >= 9) ? $urandom_range(30, 60) : $urandom_range(60, 150);
            for (int k = 0; k < span && items_taken < ITEM_TARGET; k++)
            begin
                m = row_mask();
                r.state_index = IDX_W'($urandom);
                if ($urandom_range(0, 9) < 4)
                begin
                    r.command = CMD_WRITE;
                    r.amp_re  = rand_amp();
                    r.amp_im  = rand_amp();
                end
                else
                begin
                    // amplitude fields are don't-care on a compute
                    r.command = CMD_COMPUTE;
                    r.amp_re  = 16'($urandom);
                    r.amp_im  = 16'($urandom);
                    cover_neighbors(r.state_index & m);
                end
                send_item(r, 1'b0, '0);
            end
        end

        // drain, then leave room for any stray row
        settle();
        repeat (16) @(posedge clk);
        if (flaws == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // watchdog, far past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
